// ----- rtl/core/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Status, request and unit codes, config layout, stage payloads and the
// reciprocal constants used for the distance conversion.
// ----------------------------------------------------------------------------
package uer_pkg;

  // time stamps and pulse width
  localparam int TIME_W = 32;
  localparam int PROD_W = 2 * TIME_W;

  // config registers
  localparam int TIMEOUT_W  = 20;
  localparam int DEBOUNCE_W = 10;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 1'b0,
    CFG_DEBOUNCE = 1'b1
  } cfg_idx_t;

  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 20'd38000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;

  typedef struct packed {
    logic [TIMEOUT_W-1:0]  timeout_us;
    logic [DEBOUNCE_W-1:0] debounce_ms;
  } cfg_t;

  // request kinds
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_ECHO  = 2'd1,
    REQ_PRESS = 2'd2
  } req_t;

  // measurement phase, also the reported status
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_WAIT_START = 3'd1,
    PH_WAIT_STOP  = 3'd2,
    PH_TIMEOUT    = 3'd3,
    PH_READY      = 3'd4,
    PH_ERROR      = 3'd5
  } phase_t;

  // display unit
  typedef enum logic [1:0] {
    UNIT_MM = 2'd0,
    UNIT_CM = 2'd1,
    UNIT_M  = 2'd2,
    UNIT_IN = 2'd3
  } unit_t;

  // result of the state update stage
  typedef struct packed {
    phase_t              status;
    logic [TIME_W-1:0]   pulse_width;
    unit_t               unit;
    logic                taken;
  } s1_t;

  // final result
  typedef struct packed {
    phase_t              status;
    logic [TIME_W-1:0]   distance;
    logic [TIME_W-1:0]   pulse_width;
    unit_t               unit;
    logic                taken;
  } res_t;

  // exact reciprocals: floor(t/d) = (t*RCP) >> SH, 32-bit t (RCP_37: t < 2^30)
  localparam logic [TIME_W-1:0] RCP_29   = 32'd2369637129;
  localparam int                SH_29    = 36;
  localparam logic [TIME_W-1:0] RCP_58   = 32'd2369637129;
  localparam int                SH_58    = 37;
  localparam logic [TIME_W-1:0] RCP_5800 = 32'd3033135525;
  localparam int                SH_5800  = 44;
  // inches: t/148 = (t>>2)/37
  localparam int                IN_PRE_SH = 2;
  localparam logic [TIME_W-1:0] RCP_37   = 32'd1857283156;
  localparam int                SH_37    = 36;

  // millimetres: floor(5t/29) = 5*q + floor(5*r/29), q = t/29, r = t%29
  localparam logic [TIME_W-1:0] MM_DEN = 32'd29;
  localparam logic [TIME_W-1:0] MM_MUL = 32'd5;
  localparam int                REM_W  = 5;

  // floor(5*r/29) for r in 0..28
  function automatic logic [2:0] mm_frac(input logic [REM_W-1:0] r);
    logic [7:0] r5;
    r5 = ({3'b000, r} << 2) + {3'b000, r};
    mm_frac = 3'({2'b00, r5 >= 8'd29} + {2'b00, r5 >= 8'd58}
                 + {2'b00, r5 >= 8'd87} + {2'b00, r5 >= 8'd116});
  endfunction

endpackage

// ----- rtl/core/uer_cfg.sv -----
// ----------------------------------------------------------------------------
// uer_cfg: configuration registers
// Echo timeout and debounce window, written through the cfg request port.
// ----------------------------------------------------------------------------
module uer_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output uer_pkg::cfg_t                       cfg
);

  uer_pkg::cfg_t cfg_r;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_us  <= uer_pkg::TIMEOUT_RST;
      cfg_r.debounce_ms <= uer_pkg::DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (uer_pkg::cfg_idx_t'(cfg_index))
        uer_pkg::CFG_TIMEOUT:  cfg_r.timeout_us  <= cfg_wdata[uer_pkg::TIMEOUT_W-1:0];
        uer_pkg::CFG_DEBOUNCE: cfg_r.debounce_ms <= cfg_wdata[uer_pkg::DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/uer_ctrl.sv -----
// ----------------------------------------------------------------------------
// uer_ctrl: measurement and button state
// Updates phase, echo timing, unit and debounce state for one request and
// registers the resulting status, pulse width, unit and press flag.
// ----------------------------------------------------------------------------
module uer_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [1:0]                   req_type,
  input  logic [uer_pkg::TIME_W-1:0]   time_us,
  input  logic [uer_pkg::TIME_W-1:0]   time_ms,
  input  uer_pkg::cfg_t                cfg,
  output uer_pkg::s1_t                 s1
);

  uer_pkg::phase_t                phase_r, phase_nxt;
  logic [uer_pkg::TIME_W-1:0]     start_r, start_nxt;
  logic [uer_pkg::TIME_W-1:0]     pw_r, pw_nxt;
  uer_pkg::unit_t                 unit_r, unit_nxt;
  logic                           half_r, half_nxt;
  logic [uer_pkg::TIME_W-1:0]     last_r, last_nxt;
  logic                           taken;
  logic [uer_pkg::TIME_W-1:0]     echo_width;
  logic [uer_pkg::TIME_W-1:0]     press_gap;
  uer_pkg::s1_t                   s1_r, s1_nxt;

  // modular differences
  assign echo_width = time_us - start_r;
  assign press_gap  = time_ms - last_r;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    pw_nxt    = pw_r;
    unit_nxt  = unit_r;
    half_nxt  = half_r;
    last_nxt  = last_r;
    taken     = 1'b0;
    if (take) begin
      unique case (uer_pkg::req_t'(req_type))
        uer_pkg::REQ_START: phase_nxt = uer_pkg::PH_WAIT_START;
        uer_pkg::REQ_ECHO: begin
          priority if (phase_r == uer_pkg::PH_WAIT_START) begin
            start_nxt = time_us;
            phase_nxt = uer_pkg::PH_WAIT_STOP;
          end else if (phase_r == uer_pkg::PH_WAIT_STOP) begin
            pw_nxt    = echo_width;
            phase_nxt = (echo_width >= uer_pkg::TIME_W'(cfg.timeout_us)) ?
                        uer_pkg::PH_TIMEOUT : uer_pkg::PH_READY;
          end else begin
            phase_nxt = uer_pkg::PH_ERROR;
          end
        end
        uer_pkg::REQ_PRESS: begin
          if (press_gap >= uer_pkg::TIME_W'(cfg.debounce_ms)) begin
            last_nxt = time_ms;
            if (half_r) begin
              unit_nxt = uer_pkg::unit_t'(2'(unit_r + 2'd1));
            end
            half_nxt = ~half_r;
            taken    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // stage result
  always_comb begin
    s1_nxt.status      = phase_nxt;
    s1_nxt.pulse_width = pw_nxt;
    s1_nxt.unit        = unit_nxt;
    s1_nxt.taken       = taken;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uer_pkg::PH_IDLE;
      start_r <= '0;
      pw_r    <= '0;
      unit_r  <= uer_pkg::UNIT_CM;
      half_r  <= 1'b0;
      last_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      pw_r    <= pw_nxt;
      unit_r  <= unit_nxt;
      half_r  <= half_nxt;
      last_r  <= last_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

  // once started, the phase never returns to idle
  a_no_idle_return: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != uer_pkg::PH_IDLE) |=> (phase_r != uer_pkg::PH_IDLE))
    else $error("phase returned to idle");

  // the unit only moves on a button press
  a_unit_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && (req_type == uer_pkg::REQ_PRESS)) |=> $stable(unit_r))
    else $error("unit changed without a press");

  // the unit moves only on every second taken press
  a_unit_half: assert property (@(posedge clk) disable iff (!rst_n)
    (unit_r != $past(unit_r)) |-> (!half_r && $past(half_r)))
    else $error("unit changed on the first half of a press pair");

endmodule

// ----- rtl/core/uer_conv.sv -----
// ----------------------------------------------------------------------------
// uer_conv: pulse width to distance conversion
// Multiplies the pulse width by a unit-selected reciprocal, then shifts and,
// for millimetres, adds the remainder correction into the result register.
// ----------------------------------------------------------------------------
module uer_conv (
  input  logic           clk,
  input  logic           ld_mul,
  input  logic           ld_out,
  input  uer_pkg::s1_t   s1,
  output uer_pkg::res_t  res
);

  logic [uer_pkg::TIME_W-1:0]  mul_a;
  logic [uer_pkg::TIME_W-1:0]  mul_b;
  logic [uer_pkg::PROD_W-1:0]  prod_nxt;
  logic [uer_pkg::PROD_W-1:0]  prod_r;
  uer_pkg::s1_t                s2_r;
  logic [uer_pkg::TIME_W-1:0]  quo;
  logic [uer_pkg::TIME_W-1:0]  mm_rem;
  logic [uer_pkg::TIME_W-1:0]  unit_dist;
  uer_pkg::res_t               res_r, res_nxt;

  // reciprocal select
  always_comb begin
    unique case (s1.unit)
      uer_pkg::UNIT_MM: begin
        mul_a = s1.pulse_width;
        mul_b = uer_pkg::RCP_29;
      end
      uer_pkg::UNIT_CM: begin
        mul_a = s1.pulse_width;
        mul_b = uer_pkg::RCP_58;
      end
      uer_pkg::UNIT_M: begin
        mul_a = s1.pulse_width;
        mul_b = uer_pkg::RCP_5800;
      end
      default: begin
        mul_a = s1.pulse_width >> uer_pkg::IN_PRE_SH;
        mul_b = uer_pkg::RCP_37;
      end
    endcase
  end

  assign prod_nxt = uer_pkg::PROD_W'(mul_a) * uer_pkg::PROD_W'(mul_b);

  // multiply stage
  always_ff @(posedge clk) begin
    if (ld_mul) begin
      prod_r <= prod_nxt;
      s2_r   <= s1;
    end
  end

  // quotient by unit
  always_comb begin
    unique case (s2_r.unit)
      uer_pkg::UNIT_MM: quo = uer_pkg::TIME_W'(prod_r >> uer_pkg::SH_29);
      uer_pkg::UNIT_CM: quo = uer_pkg::TIME_W'(prod_r >> uer_pkg::SH_58);
      uer_pkg::UNIT_M:  quo = uer_pkg::TIME_W'(prod_r >> uer_pkg::SH_5800);
      default:          quo = uer_pkg::TIME_W'(prod_r >> uer_pkg::SH_37);
    endcase
  end

  // millimetre correction: 5*q + floor(5*r/29)
  assign mm_rem = s2_r.pulse_width - quo * uer_pkg::MM_DEN;

  always_comb begin
    if (s2_r.unit == uer_pkg::UNIT_MM) begin
      unit_dist = quo * uer_pkg::MM_MUL
                + uer_pkg::TIME_W'(uer_pkg::mm_frac(mm_rem[uer_pkg::REM_W-1:0]));
    end else begin
      unit_dist = quo;
    end
  end

  always_comb begin
    res_nxt.status      = s2_r.status;
    res_nxt.distance    = unit_dist;
    res_nxt.pulse_width = s2_r.pulse_width;
    res_nxt.unit        = s2_r.unit;
    res_nxt.taken       = s2_r.taken;
  end

  // result register
  always_ff @(posedge clk) begin
    if (ld_out) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// Stages: input register, then state update, multiply and result register.
// Throughput: one request per cycle; the four-stage pipeline only stalls
// when every stage is full and out_stall is high.
// Reset (rst_n low, synchronous): pipeline empty, phase idle, unit cm,
// timeout 38000 us, debounce 50 ms; no clearing pass.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: echo pulse ranging with unit button
// Measures echo pulse widths from time-stamped edges, flags timeouts and
// errors, converts to the selected unit and debounces the unit button.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [uer_pkg::TIME_W-1:0]          in_time_us,
  input  logic [uer_pkg::TIME_W-1:0]          in_time_ms,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic [uer_pkg::TIME_W-1:0]          out_distance,
  output logic [uer_pkg::TIME_W-1:0]          out_pulse_width_us,
  output logic [1:0]                          out_unit_sel,
  output logic                                out_press_taken,
  // config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic                         v0_r, v1_r, v2_r, v3_r;
  logic                         rdy0, rdy1, rdy2, rdy3;
  logic [1:0]                   req_r;
  logic [uer_pkg::TIME_W-1:0]   tus_r;
  logic [uer_pkg::TIME_W-1:0]   tms_r;
  uer_pkg::cfg_t                cfg;
  uer_pkg::s1_t                 s1;
  uer_pkg::res_t                res;

  // stage ready chain, each stage loads when empty or draining
  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  assign in_stall = !rdy0;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      req_r <= in_req_type;
      tus_r <= in_time_us;
      tms_r <= in_time_ms;
    end
  end

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (v0_r && rdy1),
    .req_type (req_r),
    .time_us  (tus_r),
    .time_ms  (tms_r),
    .cfg      (cfg),
    .s1       (s1)
  );

  uer_conv u_conv (
    .clk    (clk),
    .ld_mul (rdy2),
    .ld_out (rdy3),
    .s1     (s1),
    .res    (res)
  );

  // result ports
  assign out_valid          = v3_r;
  assign out_status         = res.status;
  assign out_distance       = res.distance;
  assign out_pulse_width_us = res.pulse_width;
  assign out_unit_sel       = res.unit;
  assign out_press_taken    = res.taken;

  // requests back up only when the whole pipeline is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v0_r && v1_r && v2_r && v3_r && out_stall))
    else $error("request stalled with a free stage");

  // a converted distance never exceeds the pulse width it came from
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance <= out_pulse_width_us))
    else $error("distance larger than pulse width");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ultrasonic echo ranger
// A directed request table and then phases of random measurement sequences,
// button presses and stray edges run under several timeout/debounce settings.
// Every result is compared against an in-bench model of the ranger or a directed table entry.
// ----------------------------------------------------------------------------
module tb;
  import uer_pkg::*;

  localparam int          PIPE_LAT    = 4;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          PHASE_ITEMS = 235;
  localparam int          MAX_PRINTS  = 50;
  localparam logic [1:0]  REQ_NONE    = 2'd3;   // unused request kind
  localparam res_t        NO_RES      = '0;

  // one row of the directed table
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] us;
    logic [31:0] ms;
    logic        known;
    res_t        want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = 2'd0;
  logic [31:0] in_time_us = 32'd0;
  logic [31:0] in_time_ms = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_distance;
  logic [31:0] out_pulse_width_us;
  logic [1:0]  out_unit_sel;
  logic        out_press_taken;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // ranger model state and its copy of the registers
  phase_t      rng_phase = PH_IDLE;
  logic [31:0] rng_echo_t0 = 32'd0;
  logic [31:0] rng_width = 32'd0;
  unit_t       rng_unit = UNIT_CM;
  logic        rng_half = 1'b0;
  logic [31:0] rng_last_press = 32'd0;
  logic [19:0] tmo_cfg = TIMEOUT_RST;
  logic [9:0]  dbn_cfg = DEBOUNCE_RST;

  res_t        pending_res[$];
  stim_row_t   dir_tab[$];
  int          err_count = 0;
  int          items_sent = 0;
  int          cycle_cnt = 0;
  int          tx_burst = 0;
  int          rx_left = 0;
  logic        rx_stall = 1'b0;
  logic [31:0] press_ms = 32'd0;

  ultrasonic_echo_ranger DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_time_us         (in_time_us),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_distance       (out_distance),
    .out_pulse_width_us (out_pulse_width_us),
    .out_unit_sel       (out_unit_sel),
    .out_press_taken    (out_press_taken),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // pulse width in the selected unit, truncated
  function automatic logic [31:0] width_in_unit(logic [31:0] w, unit_t u);
    case (u)
      UNIT_MM: return 32'((64'(w) * 64'd10) / 64'd58);
      UNIT_CM: return w / 32'd58;
      UNIT_M:  return w / 32'd5800;
      default: return w / 32'd148;
    endcase
  endfunction

  // advance the ranger model by one request and return its result
  function automatic res_t ranger_step(logic [1:0] kind, logic [31:0] us, logic [31:0] ms);
    res_t        r;
    logic        taken;
    logic [31:0] gap;
    taken = 1'b0;
    case (kind)
      REQ_START: rng_phase = PH_WAIT_START;
      REQ_ECHO: begin
        if (rng_phase == PH_WAIT_START) begin
          rng_echo_t0 = us;
          rng_phase = PH_WAIT_STOP;
        end else if (rng_phase == PH_WAIT_STOP) begin
          rng_width = us - rng_echo_t0;
          rng_phase = (rng_width >= 32'(tmo_cfg)) ? PH_TIMEOUT : PH_READY;
        end else begin
          rng_phase = PH_ERROR;
        end
      end
      REQ_PRESS: begin
        gap = ms - rng_last_press;
        if (gap >= 32'(dbn_cfg)) begin
          rng_last_press = ms;
          if (rng_half) rng_unit = unit_t'(rng_unit + 2'd1);
          rng_half = ~rng_half;
          taken = 1'b1;
        end
      end
      default: ;
    endcase
    r.status      = rng_phase;
    r.distance    = width_in_unit(rng_width, rng_unit);
    r.pulse_width = rng_width;
    r.unit        = rng_unit;
    r.taken       = taken;
    return r;
  endfunction

  // sender gap: mostly none or short, a few long, with idle-free bursts
  function automatic int pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (tx_burst > 0) begin
      tx_burst = tx_burst - 1;
      return 0;
    end
    if (pick < 3) begin
      tx_burst = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // drive one request and queue its expected result once taken
  task automatic send_event(logic [1:0] kind, logic [31:0] us, logic [31:0] ms,
                            logic known, res_t want);
    int   gap;
    res_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_time_us  <= us;
    in_time_ms  <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = ranger_step(kind, us, ms);
    pending_res.push_back(known ? want : pred);
    if (kind != REQ_NONE) items_sent++;
  endtask

  // button press at a time spread around the debounce window
  task automatic send_press();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)      press_ms = press_ms + $urandom_range(0, 32'(dbn_cfg));
    else if (pick < 8) press_ms = press_ms + 32'(dbn_cfg) + $urandom_range(0, 200);
    else if (pick < 9) press_ms = press_ms + 32'(dbn_cfg) - 32'd1;
    else               press_ms = $urandom;
    send_event(REQ_PRESS, $urandom, press_ms, 1'b0, NO_RES);
  endtask

  // stop sending until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TIMEOUT) tmo_cfg = val;
    else dbn_cfg = val[9:0];
    @(posedge clk);
  endtask

  // random traffic: mostly whole measurements, the rest presses and noise
  task automatic run_random(int n);
    int          goal;
    int unsigned pick;
    logic [31:0] t0;
    logic [31:0] w;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 149) == 0) wait_drained();
      if (pick < 70) begin
        case ($urandom_range(0, 3))
          0:       w = $urandom_range(0, 20000);
          1:       w = 32'(tmo_cfg) + $urandom_range(0, 4) - 32'd2;
          2:       w = $urandom_range(0, 32'(tmo_cfg) - 32'd1);
          default: w = $urandom;
        endcase
        t0 = $urandom;
        send_event(REQ_START, $urandom, $urandom, 1'b0, NO_RES);
        send_event(REQ_ECHO, t0, $urandom, 1'b0, NO_RES);
        // occasional interruption between the echo start and echo stop requests
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       send_press();
            1:       send_event(REQ_NONE, $urandom, $urandom, 1'b0, NO_RES);
            2:       send_event(REQ_START, $urandom, $urandom, 1'b0, NO_RES);
            default: send_event(REQ_ECHO, $urandom, $urandom, 1'b0, NO_RES);
          endcase
        end
        send_event(REQ_ECHO, t0 + w, $urandom, 1'b0, NO_RES);
      end else if (pick < 85) begin
        send_press();
      end else if (pick < 95) begin
        send_event(REQ_ECHO, $urandom, $urandom, 1'b0, NO_RES);
      end else begin
        send_event(REQ_NONE, $urandom, $urandom, 1'b0, NO_RES);
      end
    end
  endtask

  // result stall: runs of free flow, short stalls and a few long ones
  always @(posedge clk) begin : stall_gen
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (rx_left > 0) begin
      rx_left = rx_left - 1;
    end else if (pick < 10) begin
      rx_stall = 1'b0;
      rx_left = $urandom_range(20, 80);
    end else if (pick < 50) begin
      rx_stall = 1'b0;
      rx_left = $urandom_range(0, 4);
    end else if (pick < 92) begin
      rx_stall = 1'b1;
      rx_left = $urandom_range(0, 3);
    end else begin
      rx_stall = 1'b1;
      rx_left = $urandom_range(10, 50);
    end
    out_stall <= rx_stall;
  end

  // compare each taken result with the oldest pending one
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        report_mismatch("result with none pending", 32'(out_status), 32'd0);
      end else begin
        want = pending_res.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_distance !== want.distance)
          report_mismatch("distance", out_distance, want.distance);
        if (out_pulse_width_us !== want.pulse_width)
          report_mismatch("pulse_width_us", out_pulse_width_us, want.pulse_width);
        if (out_unit_sel !== want.unit)
          report_mismatch("unit_sel", 32'(out_unit_sel), 32'(want.unit));
        if (out_press_taken !== want.taken)
          report_mismatch("press_taken", 32'(out_press_taken), 32'(want.taken));
      end
    end
  end

  // main sequence
  initial begin : main_seq
    int          ph;
    logic [19:0] tmo_v;
    logic [19:0] dbn_v;
    // directed requests under the reset settings
    dir_tab.push_back('{REQ_NONE, 32'd0, 32'd0, 1'b1,
                        '{PH_IDLE, 32'd0, 32'd0, UNIT_CM, 1'b0}});
    dir_tab.push_back('{REQ_ECHO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                        '{PH_ERROR, 32'd0, 32'd0, UNIT_CM, 1'b0}});
    dir_tab.push_back('{REQ_PRESS, 32'd0, 32'd10, 1'b1,
                        '{PH_ERROR, 32'd0, 32'd0, UNIT_CM, 1'b0}});
    dir_tab.push_back('{REQ_PRESS, 32'd0, 32'd50, 1'b1,
                        '{PH_ERROR, 32'd0, 32'd0, UNIT_CM, 1'b1}});
    dir_tab.push_back('{REQ_PRESS, 32'd0, 32'd99, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_PRESS, 32'd0, 32'd100, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                        '{PH_WAIT_START, 32'd0, 32'd0, UNIT_M, 1'b0}});
    dir_tab.push_back('{REQ_ECHO, 32'hFFFF_FFF0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_START, 32'd0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'hFFFF_FFF0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'h0000_0010, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_NONE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'd5, 32'd0, 1'b0, NO_RES});
    // just under the timeout, then exactly at it
    dir_tab.push_back('{REQ_START, 32'd0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'd1000, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'd38999, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_START, 32'd0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'd0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'd38000, 32'd0, 1'b0, NO_RES});
    // widest pulse
    dir_tab.push_back('{REQ_START, 32'd0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'd0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_ECHO, 32'hFFFF_FFFF, 32'd0, 1'b0, NO_RES});
    // press times across the wrap of the millisecond counter
    dir_tab.push_back('{REQ_PRESS, 32'd0, 32'hFFFF_FFFF, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_PRESS, 32'd0, 32'd0, 1'b0, NO_RES});
    dir_tab.push_back('{REQ_PRESS, 32'd0, 32'd49, 1'b0, NO_RES});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_event(dir_tab[i].kind, dir_tab[i].us, dir_tab[i].ms, dir_tab[i].known,
                 dir_tab[i].want);
    press_ms = 32'd49;

    // random phases, registers rewritten only when drained
    for (ph = 0; ph < 7; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          tmo_v = 20'd1;
          dbn_v = 20'd0;
        end
        1: begin
          tmo_v = 20'd1000000;
          dbn_v = 20'd1000;
        end
        2: begin
          tmo_v = 20'(TIMEOUT_RST);
          dbn_v = 20'(DEBOUNCE_RST);
        end
        3: begin
          tmo_v = 20'($urandom_range(1, 3000));
          dbn_v = 20'($urandom_range(0, 20));
        end
        default: begin
          tmo_v = 20'($urandom_range(1, 1000000));
          dbn_v = 20'($urandom_range(0, 1000));
        end
      endcase
      write_reg(CFG_TIMEOUT, tmo_v);
      write_reg(CFG_DEBOUNCE, dbn_v);
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- ultrasonic_echo_ranger.f -----
rtl/core/uer_pkg.sv
rtl/core/uer_cfg.sv
rtl/core/uer_ctrl.sv
rtl/core/uer_conv.sv
rtl/core/ultrasonic_echo_ranger.sv
verif/tb.sv
